// File: design/base85_stream_encoder_unit_assert.svh
// Assertion macros shared by the encoder modules.
// Each macro expects clk and arst_n to be visible at the place of use.
`ifndef BASE85_STREAM_ENCODER_UNIT_ASSERT_SVH
`define BASE85_STREAM_ENCODER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define B85E_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define B85E_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define B85E_ASSERT(lbl, prop, msg)
`define B85E_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// File: design/b85e_pkg.sv
package b85e_pkg;

	localparam int unsigned WORD_W     = 32;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned CHAR_W     = 7;
	localparam int unsigned NUM_DIGITS = 5;

	typedef logic [CHAR_W-1:0] digit_t;
	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [WORD_W-1:0] word_t;
	typedef logic [1:0]        byte_cnt_t;
	typedef logic [2:0]        step_t;
	typedef logic [2:0]        char_idx_t;

	// floor(x / 85) == (x * RECIP_85) >> RECIP_SHIFT for every 32-bit x
	localparam word_t          RECIP_85    = 32'hC0C0C0C1;
	localparam int unsigned    RECIP_SHIFT = 38;
	localparam logic [CHAR_W-1:0] RADIX    = 7'd85;

	localparam byte_cnt_t LAST_BYTE_SLOT = 2'd3;
	localparam step_t     LAST_STEP      = 3'd4;
	localparam char_idx_t IDX_LAST_DIGIT = 3'd4;
	localparam char_idx_t IDX_TERM       = 3'd5;

	localparam char_t TERM_CHAR = 7'h5D;
	localparam char_t TOP_CHAR  = 7'h7E;

	// punctuation tail of the alphabet, digits 62 to 84
	localparam char_t PUNCT_CHARS [23] = '{
		7'd33, 7'd35, 7'd36, 7'd37, 7'd38, 7'd40, 7'd41, 7'd42,
		7'd43, 7'd45, 7'd59, 7'd60, 7'd61, 7'd62, 7'd63, 7'd64,
		7'd94, 7'd95, 7'd96, 7'd123, 7'd124, 7'd125, 7'd126
	};

	typedef struct packed {
		word_t word;
		logic  grp;
		logic  term;
	} job_t;

	typedef struct packed {
		digit_t [NUM_DIGITS-1:0] digits;
		logic                    grp;
		logic                    term;
	} group_t;

	function automatic char_t b85_char(input digit_t d);
		digit_t off;
		char_t  c;
		off = d - 7'd62;
		if (d < 7'd10) begin
			c = d + 7'd48;
		end else if (d < 7'd36) begin
			c = d + 7'd55;
		end else if (d < 7'd62) begin
			c = d + 7'd61;
		end else if (d < RADIX) begin
			c = PUNCT_CHARS[off[4:0]];
		end else begin
			c = TOP_CHAR;
		end
		return c;
	endfunction

endpackage

// File: design/base85_stream_encoder_unit.sv
// Channel   Dir  tdata                      tuser           tlast
// s_*       in   [7:0] data_byte            has_byte        last_byte
// m_*       out  [6:0] out_char, [7] zero   -               last_char
//
// One byte per cycle enters the group register while s_tready is high; each full or
// flushed group then passes the divide-by-85 unit (load, five digit steps). The output
// register sends at most one character per cycle, holding while m_tready is low: five per
// group, then ']' at stream end; a group passes the job, result, group and output registers.
// Reset: arst_n clears the open group and all pipeline valids at once. Stalls: m_tready
// low holds the output and backs up to s_tready; an idle item is taken and leaves no trace.

module base85_stream_encoder_unit import b85e_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tuser,   // [0] has_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
	output logic       m_tlast
);

	// gather -> converter: one pending group or terminator
	logic   job_valid;
	job_t   job;
	logic   job_ready;

	// converter -> emitter: five digits plus flags
	logic   res_valid;
	group_t res;
	logic   res_ready;

	char_t  out_char;

	// accumulate bytes little-endian into the open group
	b85e_gather u_gather (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.in_has    (s_tuser),
		.in_last   (s_tlast),
		.job_valid (job_valid),
		.job       (job),
		.job_ready (job_ready)
	);

	// split the word into base-85 digits over successive cycles
	b85e_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_ready (job_ready),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	// map digits to the alphabet and send them, terminator last
	b85e_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (out_char),
		.out_last  (m_tlast)
	);

	assign m_tdata = {1'b0, out_char};

endmodule

// File: design/b85e_gather.sv
`include "base85_stream_encoder_unit_assert.svh"

module b85e_gather import b85e_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [BYTE_W-1:0]  in_byte,
	input  logic               in_has,
	input  logic               in_last,
	output logic               job_valid,
	output job_t               job,
	input  logic               job_ready
);

	word_t     word_q;
	byte_cnt_t cnt_q;
	logic      job_valid_q;
	job_t      job_q;

	logic      accept;
	word_t     merged;
	logic      full;
	logic      grp;
	logic      new_job;

	assign in_ready = !job_valid_q || job_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		merged  = word_q | (word_t'(in_byte) << {cnt_q, 3'b000});
		full    = in_has && (cnt_q == LAST_BYTE_SLOT);
		grp     = full || (in_last && (in_has || (cnt_q != 2'd0)));
		new_job = grp || in_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q      <= '0;
			cnt_q       <= '0;
			job_valid_q <= 1'b0;
		end else begin
			if (accept && new_job) begin
				word_q      <= '0;
				cnt_q       <= '0;
				job_valid_q <= 1'b1;
			end else begin
				if (job_ready) job_valid_q <= 1'b0;
				if (accept && in_has) begin
					word_q <= merged;
					cnt_q  <= cnt_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && new_job) begin
			job_q.word <= in_has ? merged : word_q;
			job_q.grp  <= grp;
			job_q.term <= in_last;
		end
	end

	assign job_valid = job_valid_q;
	assign job       = job_q;

	`B85E_ASSERT(a_last_clears, accept && in_last |=> cnt_q == 2'd0 && word_q == '0, "open group left after last")

endmodule

// File: design/b85e_conv.sv
`include "base85_stream_encoder_unit_assert.svh"

module b85e_conv import b85e_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   job_valid,
	input  job_t   job,
	output logic   job_ready,
	output logic   res_valid,
	output group_t res,
	input  logic   res_ready
);

	logic   busy_q;
	step_t  step_q;
	logic   res_valid_q;
	word_t  x_q;
	word_t  xprev_q;
	group_t res_q;

	logic                  take;
	logic                  load;
	logic [2*WORD_W-1:0]   prod;
	word_t                 quot;
	logic [2*CHAR_W-1:0]   lo_prod;
	digit_t                cur_digit;

	assign take      = res_valid_q && res_ready;
	assign job_ready = !busy_q && (!res_valid_q || take);
	assign load      = job_valid && job_ready;

	// one divide-by-85 step per cycle, least significant digit first
	always_comb begin
		prod      = (2*WORD_W)'(x_q) * (2*WORD_W)'(RECIP_85);
		quot      = word_t'(prod >> RECIP_SHIFT);
		lo_prod   = (2*CHAR_W)'(x_q[CHAR_W-1:0]) * (2*CHAR_W)'(RADIX);
		cur_digit = xprev_q[CHAR_W-1:0] - lo_prod[CHAR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q      <= job.grp;
				res_valid_q <= !job.grp;
				step_q      <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == LAST_STEP) begin
					busy_q      <= 1'b0;
					res_valid_q <= 1'b1;
				end
			end else if (take) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q        <= job.word;
			res_q.grp  <= job.grp;
			res_q.term <= job.term;
		end else if (busy_q) begin
			x_q     <= quot;
			xprev_q <= x_q;
			if (step_q != 3'd0) res_q.digits[step_q - 3'd1] <= cur_digit;
			if (step_q == LAST_STEP) res_q.digits[NUM_DIGITS-1] <= x_q[CHAR_W-1:0];
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`B85E_ASSERT_NEVER(a_busy_and_done, busy_q && res_valid_q, "digits overwritten while pending")
	`B85E_ASSERT(a_step_range, busy_q |-> step_q <= LAST_STEP, "digit step out of range")

endmodule

// File: design/b85e_emit.sv
`include "base85_stream_encoder_unit_assert.svh"

module b85e_emit import b85e_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   res_valid,
	input  group_t res,
	output logic   res_ready,
	output logic   out_valid,
	input  logic   out_ready,
	output char_t  out_char,
	output logic   out_last
);

	logic      active_q;
	char_idx_t idx_q;
	group_t    grp_q;
	logic      o_valid_q;
	char_t     o_char_q;
	logic      o_last_q;

	logic   adv;
	logic   done_now;
	logic   take;
	digit_t sel_digit;
	char_t  next_char;

	assign adv       = active_q && (!o_valid_q || out_ready);
	assign done_now  = (idx_q == IDX_TERM) || ((idx_q == IDX_LAST_DIGIT) && !grp_q.term);
	assign res_ready = !active_q || (adv && done_now);
	assign take      = res_valid && res_ready;

	// most significant digit leaves first
	always_comb begin
		unique case (idx_q)
			3'd0:    sel_digit = grp_q.digits[4];
			3'd1:    sel_digit = grp_q.digits[3];
			3'd2:    sel_digit = grp_q.digits[2];
			3'd3:    sel_digit = grp_q.digits[1];
			default: sel_digit = grp_q.digits[0];
		endcase
		next_char = (idx_q == IDX_TERM) ? TERM_CHAR : b85_char(sel_digit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			idx_q     <= '0;
			o_valid_q <= 1'b0;
		end else begin
			if (take) begin
				active_q <= 1'b1;
				idx_q    <= res.grp ? 3'd0 : IDX_TERM;
			end else if (adv) begin
				if (done_now) active_q <= 1'b0;
				else idx_q <= idx_q + 3'd1;
			end
			if (adv) begin
				o_valid_q <= 1'b1;
			end else if (out_ready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) grp_q <= res;
		if (adv) begin
			o_char_q <= next_char;
			o_last_q <= (idx_q == IDX_TERM);
		end
	end

	assign out_valid = o_valid_q;
	assign out_char  = o_char_q;
	assign out_last  = o_last_q;

	`B85E_ASSERT(a_last_is_term, o_valid_q && o_last_q |-> o_char_q == TERM_CHAR, "last without terminator")
	`B85E_ASSERT(a_idx_range, active_q |-> idx_q <= IDX_TERM, "character index out of range")

endmodule
